@@ src/mlmd_pkg.sv @@
// ----------------------------------------------------------------------------
// mlmd_pkg
// Shared types and constants of the magic/length message deframer.
// ----------------------------------------------------------------------------
package mlmd_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int HDR_BITS     = HEADER_BYTES * 8;
    localparam int CNT_W        = 4;

    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = 2;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] message_type;
        logic [31:0] data;
        logic        eom;
    } mlmd_rec_t;

endpackage

@@ src/mlmd_front.sv @@
// ----------------------------------------------------------------------------
// mlmd_front
// Byte parser: gathers the header, checks the magic word and turns each
// complete header, body byte and magic mismatch into a result record.
// ----------------------------------------------------------------------------
module mlmd_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_accept,
    input  logic [7:0]         stream_byte,
    input  logic               flush,
    input  logic               magic_we,
    input  logic [31:0]        magic_wdata,
    output logic               rec_valid,
    output mlmd_pkg::mlmd_rec_t rec
);
    import mlmd_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_ERROR  = 2'd2;

    logic [1:0]          phase_reg, phase_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [31:0]         remain_reg, remain_next;
    logic [31:0]         magic_reg;
    logic [HDR_BITS-1:0] hdr_reg, hdr_next, hdr_full;

    assign hdr_full = {hdr_reg[HDR_BITS-9:0], stream_byte};

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        hdr_next    = hdr_reg;
        rec_valid   = 1'b0;
        rec         = '0;
        if (in_accept)
        begin
            if (flush)
            begin
                phase_next  = PH_HEADER;
                count_next  = '0;
                remain_next = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_ERROR:
                    begin
                        phase_next = PH_ERROR;
                    end
                    PH_BODY:
                    begin
                        remain_next   = remain_reg - 32'd1;
                        rec_valid     = 1'b1;
                        rec.kind      = KIND_BODY;
                        rec.data      = {24'd0, stream_byte};
                        rec.eom       = (remain_reg == 32'd1);
                        if (remain_reg == 32'd1)
                        begin
                            phase_next = PH_HEADER;
                            count_next = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                        hdr_next   = hdr_full;
                        if (count_reg == CNT_W'(HEADER_BYTES - 1))
                        begin
                            count_next = '0;
                            rec_valid  = 1'b1;
                            if (hdr_full[95:64] != magic_reg)
                            begin
                                phase_next = PH_ERROR;
                                rec.kind   = KIND_ERROR;
                            end
                            else
                            begin
                                rec.kind         = KIND_HEADER;
                                rec.message_type = hdr_full[63:32];
                                rec.data         = hdr_full[31:0];
                                if (hdr_full[31:0] == 32'd0)
                                begin
                                    rec.eom = 1'b1;
                                end
                                else
                                begin
                                    phase_next  = PH_BODY;
                                    remain_next = hdr_full[31:0];
                                end
                            end
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            count_reg  <= '0;
            remain_reg <= '0;
            magic_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            if (magic_we)
            begin
                magic_reg <= magic_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
    end

endmodule

@@ src/mlmd_fifo.sv @@
// ----------------------------------------------------------------------------
// mlmd_fifo
// Short record queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
module mlmd_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  mlmd_pkg::mlmd_rec_t wr_data,
    input  logic                rd_en,
    output mlmd_pkg::mlmd_rec_t rd_data,
    output logic                fifo_full,
    output logic                fifo_empty
);
    import mlmd_pkg::*;

    mlmd_rec_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg, wptr_next;
    logic [FIFO_AW-1:0] rptr_reg, rptr_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;

    assign fifo_full  = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign fifo_empty = (cnt_reg == '0);
    assign rd_data    = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wr_en ? wptr_reg + FIFO_AW'(1) : wptr_reg;
        rptr_next = rd_en ? rptr_reg + FIFO_AW'(1) : rptr_reg;
        cnt_next  = cnt_reg + (FIFO_AW+1)'(wr_en) - (FIFO_AW+1)'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

endmodule

@@ src/mlmd_back.sv @@
// ----------------------------------------------------------------------------
// mlmd_back
// Output stage: takes records from the queue into a result register and
// expands them into the result fields.
// ----------------------------------------------------------------------------
module mlmd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  mlmd_pkg::mlmd_rec_t q_data,
    input  logic                q_empty,
    output logic                q_rd,
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          kind,
    output logic [31:0]         message_type,
    output logic [31:0]         body_length,
    output logic [7:0]          body_byte,
    output logic                end_of_message
);
    import mlmd_pkg::*;

    mlmd_rec_t out_reg;
    logic      valid_reg, valid_next;

    assign q_rd       = !q_empty && (!valid_reg || pop);
    assign valid_next = q_rd || (valid_reg && !pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            out_reg <= q_data;
        end
    end

    assign empty          = !valid_reg;
    assign kind           = out_reg.kind;
    assign message_type   = (out_reg.kind == KIND_HEADER) ? out_reg.message_type : 32'd0;
    assign body_length    = (out_reg.kind == KIND_HEADER) ? out_reg.data : 32'd0;
    assign body_byte      = (out_reg.kind == KIND_BODY) ? out_reg.data[7:0] : 8'd0;
    assign end_of_message = out_reg.eom;

endmodule

@@ src/magic_length_message_deframer_top.sv @@
// ----------------------------------------------------------------------------
// magic_length_message_deframer_top
// Deframes a byte stream of 12-byte headers (magic, type, length, big-endian)
// followed by length body bytes.
//
// Input side is a queue write port: a beat is taken when push is high and
// full is low. Each beat carries stream_byte and flush. A flush beat drops
// any partial header, any body in progress and any sticky magic error.
// Result side is a queue read port: the oldest result sits on the result
// ports while empty is low and leaves when pop is high.
// One byte is taken every cycle while full is low. A result passes through
// the record queue and the output register before the result ports; the
// four-entry record queue plus the output register absorb a stalled receiver,
// and full rises only when the record queue fills. A magic mismatch gives one
// error result and then silently drops bytes until a flush. The user must
// write the expected magic word through magic_we and magic_wdata only while
// the block is idle; the block does not enforce this. Reset empties both
// queues, clears the magic word and returns the parser to header collection.
// ----------------------------------------------------------------------------
module magic_length_message_deframer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  stream_byte,
    input  logic        flush,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [31:0] message_type,
    output logic [31:0] body_length,
    output logic [7:0]  body_byte,
    output logic        end_of_message,
    input  logic        magic_we,
    input  logic [31:0] magic_wdata
);
    import mlmd_pkg::*;

    logic      in_accept;
    logic      rec_valid;
    mlmd_rec_t rec;
    mlmd_rec_t q_data;
    logic      q_rd;
    logic      q_empty;
    logic      q_full;

    assign full      = q_full;
    assign in_accept = push && !q_full;

    mlmd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .stream_byte (stream_byte),
        .flush       (flush),
        .magic_we    (magic_we),
        .magic_wdata (magic_wdata),
        .rec_valid   (rec_valid),
        .rec         (rec)
    );

    mlmd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (rec_valid),
        .wr_data    (rec),
        .rd_en      (q_rd),
        .rd_data    (q_data),
        .fifo_full  (q_full),
        .fifo_empty (q_empty)
    );

    mlmd_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_data         (q_data),
        .q_empty        (q_empty),
        .q_rd           (q_rd),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .message_type   (message_type),
        .body_length    (body_length),
        .body_byte      (body_byte),
        .end_of_message (end_of_message)
    );

endmodule

@@ src/mlmd_checker.sv @@
// ----------------------------------------------------------------------------
// mlmd_checker
// Port-level checks of the deframer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module mlmd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  kind,
    input logic [31:0] message_type,
    input logic [31:0] body_length,
    input logic [7:0]  body_byte,
    input logic        end_of_message
);
    import mlmd_pkg::*;

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (kind == KIND_HEADER || kind == KIND_BODY || kind == KIND_ERROR))
        else $error("result carries an unknown kind");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_ERROR) |->
        (message_type == 32'd0 && body_length == 32'd0 && body_byte == 8'd0 &&
         !end_of_message))
        else $error("error result carries nonzero fields");

    a_header_eom: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_HEADER) |-> (end_of_message == (body_length == 32'd0)))
        else $error("header end mark disagrees with body length");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(body_byte)))
        else $error("stalled result changed or vanished");

endmodule

bind magic_length_message_deframer_top mlmd_checker u_mlmd_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .kind           (kind),
    .message_type   (message_type),
    .body_length    (body_length),
    .body_byte      (body_byte),
    .end_of_message (end_of_message)
);
